// ===== rtl/core/ledser_pkg.sv =====
package ledser_pkg;

  // Bits in one channel word and in the register word
  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned CNT_W     = $clog2(WORD_BITS);
  localparam int unsigned LANES     = 6;

  // Command kinds
  typedef enum logic [2:0] {
    KIND_PIXEL  = 3'd0,
    KIND_REG    = 3'd1,
    KIND_VSYNC  = 3'd2,
    KIND_PREACT = 3'd3,
    KIND_EDGE   = 3'd4,
    KIND_ROW    = 3'd5
  } kind_t;

  // Register write: LE is high on this many trailing bits
  localparam logic [CNT_W-1:0] REG_LATCH_TAIL = CNT_W'(5);
  // First beat index of the latch tail
  localparam logic [CNT_W-1:0] REG_TAIL_START = CNT_W'(WORD_BITS - REG_LATCH_TAIL);
  localparam logic [CNT_W-1:0] LAST_BIT       = CNT_W'(WORD_BITS - 1);

  // High-time of the pulse commands, in clocks
  localparam logic [CNT_W-1:0] VSYNC_CLOCKS       = CNT_W'(3);
  localparam logic [CNT_W-1:0] PREACT_CLOCKS      = CNT_W'(14);
  localparam logic [CNT_W-1:0] BOTH_EDGE_CLOCKS   = CNT_W'(15);
  localparam logic [CNT_W-1:0] SINGLE_EDGE_CLOCKS = CNT_W'(2);
  localparam logic [CNT_W-1:0] FIRST_ROW_CLOCKS   = CNT_W'(12);
  localparam logic [CNT_W-1:0] OTHER_ROW_CLOCKS   = CNT_W'(4);

endpackage

// ===== rtl/core/led_driver_command_serializer.sv =====
// LED driver command serializer. Each accepted command becomes a train of pin patterns on
// the out_ channel, one transfer per driver clock: six color lines, LE and ROW, with
// out_last on the final one. A pixel word or a register write takes 16 transfers; vsync
// takes 4, pre-activate 15, edge mode 16 (dual) or 3 (single), and a row pulse 13 (first
// line) or 5. At most one pattern leaves per cycle, and the next command is taken in the
// same cycle as the final transfer. The pace is set by the six 16-bit shift lanes, which
// move one bit per cycle unless out_stall holds them, and the 4-bit beat counter. Kinds 6
// and 7 are taken and dropped without any output transfer. There is no configuration and
// no clearing pass after reset.
module led_driver_command_serializer
  import ledser_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_red_lo,
  input  logic [15:0] in_green_lo,
  input  logic [15:0] in_blue_lo,
  input  logic [15:0] in_red_hi,
  input  logic [15:0] in_green_hi,
  input  logic [15:0] in_blue_hi,
  input  logic        in_latch,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_reg_value,
  input  logic        in_both_edges,
  input  logic        in_first_row,
  // pin pattern channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_color_bits,
  output logic        out_latch_enable,
  output logic        out_row_line,
  output logic        out_last
);

  // One-hot sequencer: idle, shifting a word, holding LE or ROW
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;       // beat index within the command
  logic [CNT_W-1:0]       len_r, len_nxt;       // high-time of a pulse command
  logic                   latch_r, latch_nxt;
  logic                   is_reg_r, is_reg_nxt; // shifting a register word
  logic                   on_row_r, on_row_nxt; // pulse goes to ROW, not LE
  logic [WORD_BITS-1:0]   lane_r   [LANES];
  logic [WORD_BITS-1:0]   lane_nxt [LANES];

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   shifting;
  logic                   holding;
  logic                   level;
  logic [WORD_BITS-1:0]   reg_word;

  assign shifting = (state_r == ST_SHIFT);
  assign holding  = (state_r == ST_HOLD);
  assign reg_word = {in_reg_addr, in_reg_value};

  // Pulse level: high on every beat but the closing one
  assign level = (cnt_r != len_r);

  // Outputs come straight from the lane MSBs and the beat counter
  assign out_valid = !(state_r == ST_IDLE);
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      out_color_bits[i] = shifting & lane_r[i][WORD_BITS-1];
    end
  end
  assign out_last = shifting ? (cnt_r == LAST_BIT) : (holding & !level);
  assign out_latch_enable =
      shifting ? (latch_r & (is_reg_r ? (cnt_r >= REG_TAIL_START) : (cnt_r == LAST_BIT)))
               : (holding & !on_row_r & level);
  assign out_row_line = holding & on_row_r & level;

  assign out_xfer = out_valid && !out_stall;
  // Take a new command when idle or as the final pattern of the current one leaves
  assign in_stall = !((state_r == ST_IDLE) || (out_xfer && out_last));
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    latch_nxt  = latch_r;
    is_reg_nxt = is_reg_r;
    on_row_nxt = on_row_r;
    for (int i = 0; i < LANES; i++) begin
      lane_nxt[i] = lane_r[i];
    end

    // Advance one beat per output transfer; drop to idle after the final one
    if (out_xfer) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (shifting) begin
        for (int i = 0; i < LANES; i++) begin
          lane_nxt[i] = {lane_r[i][WORD_BITS-2:0], 1'b0};
        end
      end
      if (out_last) begin
        state_nxt = ST_IDLE;
      end
    end

    // Load a new command
    if (in_xfer) begin
      cnt_nxt    = '0;
      latch_nxt  = in_latch;
      is_reg_nxt = 1'b0;
      on_row_nxt = 1'b0;
      unique case (kind_t'(in_kind))
        KIND_PIXEL: begin
          state_nxt   = ST_SHIFT;
          lane_nxt[0] = in_red_lo;
          lane_nxt[1] = in_green_lo;
          lane_nxt[2] = in_blue_lo;
          lane_nxt[3] = in_red_hi;
          lane_nxt[4] = in_green_hi;
          lane_nxt[5] = in_blue_hi;
        end
        KIND_REG: begin
          // Same word on all six lines
          state_nxt  = ST_SHIFT;
          is_reg_nxt = 1'b1;
          for (int i = 0; i < LANES; i++) begin
            lane_nxt[i] = reg_word;
          end
        end
        KIND_VSYNC: begin
          state_nxt = ST_HOLD;
          len_nxt   = VSYNC_CLOCKS;
        end
        KIND_PREACT: begin
          state_nxt = ST_HOLD;
          len_nxt   = PREACT_CLOCKS;
        end
        KIND_EDGE: begin
          state_nxt = ST_HOLD;
          len_nxt   = in_both_edges ? BOTH_EDGE_CLOCKS : SINGLE_EDGE_CLOCKS;
        end
        KIND_ROW: begin
          state_nxt  = ST_HOLD;
          on_row_nxt = 1'b1;
          len_nxt    = in_first_row ? FIRST_ROW_CLOCKS : OTHER_ROW_CLOCKS;
        end
        default: begin
          // Unknown kind: drop it, nothing goes out
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload and beat bookkeeping; only meaningful while not idle
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    len_r    <= len_nxt;
    latch_r  <= latch_nxt;
    is_reg_r <= is_reg_nxt;
    on_row_r <= on_row_nxt;
    for (int i = 0; i < LANES; i++) begin
      lane_r[i] <= lane_nxt[i];
    end
  end

endmodule

// ===== rtl/core/ledser_chk.sv =====
module ledser_chk
  import ledser_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_color_bits,
  input logic        out_latch_enable,
  input logic        out_row_line,
  input logic        out_last
);

  // LE and ROW are never driven high together
  a_le_row_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_latch_enable && out_row_line))
    else $error("LE and ROW high together");

  // A row pulse keeps the color lines low
  a_row_dark : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_line) |-> (out_color_bits == 6'd0))
    else $error("color lines active during row pulse");

  // A pixel word starts streaming on the next cycle and is not done after one bit
  a_pixel_start : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_PIXEL)) |=> (out_valid && !out_last))
    else $error("pixel word did not start");

  // No new command is taken in the middle of one
  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("command taken mid-stream");

  // A stalled pattern holds
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_color_bits)
      && $stable(out_latch_enable) && $stable(out_row_line) && $stable(out_last)))
    else $error("stalled pattern changed");

endmodule

bind led_driver_command_serializer ledser_chk u_ledser_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_color_bits   (out_color_bits),
  .out_latch_enable (out_latch_enable),
  .out_row_line     (out_row_line),
  .out_last         (out_last)
);

// ===== tb/led_driver_command_serializer_test.sv =====
`timescale 1ns / 100ps

module led_driver_command_serializer_test;
  import ledser_pkg::*;

  // Kinds outside the command set: the block takes them and drops them
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // Worst run: ~550 commands x 16 patterns, each waiting out receiver stalls,
  // plus sender gaps. This is several times that.
  localparam int CYCLE_LIMIT   = 400000;
  // Quiet time after the last expected pattern, to catch stray transfers
  localparam int TAIL_CYCLES   = 40;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] red_lo;
    logic [15:0] green_lo;
    logic [15:0] blue_lo;
    logic [15:0] red_hi;
    logic [15:0] green_hi;
    logic [15:0] blue_hi;
    logic        latch;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic        both_edges;
    logic        first_row;
  } led_command_t;

  // One driver clock worth of pin levels
  typedef struct packed {
    logic [5:0] color_bits;
    logic       latch_enable;
    logic       row_line;
    logic       last_beat;
  } pin_pattern_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [15:0] in_red_lo = '0;
  logic [15:0] in_green_lo = '0;
  logic [15:0] in_blue_lo = '0;
  logic [15:0] in_red_hi = '0;
  logic [15:0] in_green_hi = '0;
  logic [15:0] in_blue_hi = '0;
  logic        in_latch = 1'b0;
  logic [7:0]  in_reg_addr = '0;
  logic [7:0]  in_reg_value = '0;
  logic        in_both_edges = 1'b0;
  logic        in_first_row = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_color_bits;
  logic        out_latch_enable;
  logic        out_row_line;
  logic        out_last;

  // Pin patterns still owed by the block, oldest first
  pin_pattern_t expected_pins[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  // Chance per cycle, in percent, that each side holds off
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  led_driver_command_serializer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_red_lo        (in_red_lo),
    .in_green_lo      (in_green_lo),
    .in_blue_lo       (in_blue_lo),
    .in_red_hi        (in_red_hi),
    .in_green_hi      (in_green_hi),
    .in_blue_hi       (in_blue_hi),
    .in_latch         (in_latch),
    .in_reg_addr      (in_reg_addr),
    .in_reg_value     (in_reg_value),
    .in_both_edges    (in_both_edges),
    .in_first_row     (in_first_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_color_bits   (out_color_bits),
    .out_latch_enable (out_latch_enable),
    .out_row_line     (out_row_line),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Pin pattern prediction
  // ---------------------------------------------------------------------------

  // Hold LE or ROW high for the given number of clocks, then drop it on a closing beat.
  // Colors stay dark on every beat.
  function automatic void predict_line_hold(int clocks, bit on_row);
    pin_pattern_t p;
    for (int k = 0; k <= clocks; k++) begin
      p.color_bits   = '0;
      p.latch_enable = !on_row && (k < clocks);
      p.row_line     = on_row && (k < clocks);
      p.last_beat    = (k == clocks);
      expected_pins.push_back(p);
    end
  endfunction

  // Queue every pin pattern a command produces. Fields the kind does not
  // use play no part; spare kinds produce nothing.
  function automatic void predict_pin_train(led_command_t c);
    pin_pattern_t    p;
    int              pos;
    logic [15:0]     reg_word;
    reg_word = {c.reg_addr, c.reg_value};
    case (c.kind)
      KIND_PIXEL: begin
        // Six lanes shift MSB first; LE only on the final bit
        for (int k = 0; k < WORD_BITS; k++) begin
          pos = WORD_BITS - 1 - k;
          p.color_bits   = {c.blue_hi[pos], c.green_hi[pos], c.red_hi[pos],
                            c.blue_lo[pos], c.green_lo[pos], c.red_lo[pos]};
          p.last_beat    = (k == WORD_BITS - 1);
          p.latch_enable = c.latch && p.last_beat;
          p.row_line     = 1'b0;
          expected_pins.push_back(p);
        end
      end
      KIND_REG: begin
        // Same address:value bit on all six lanes; LE across the tail bits
        for (int k = 0; k < WORD_BITS; k++) begin
          pos = WORD_BITS - 1 - k;
          p.color_bits   = reg_word[pos] ? 6'h3F : 6'h00;
          p.latch_enable = c.latch && (pos < int'(REG_LATCH_TAIL));
          p.row_line     = 1'b0;
          p.last_beat    = (k == WORD_BITS - 1);
          expected_pins.push_back(p);
        end
      end
      KIND_VSYNC:  predict_line_hold(int'(VSYNC_CLOCKS), 1'b0);
      KIND_PREACT: predict_line_hold(int'(PREACT_CLOCKS), 1'b0);
      KIND_EDGE:
        predict_line_hold(c.both_edges ? int'(BOTH_EDGE_CLOCKS)
                                       : int'(SINGLE_EDGE_CLOCKS), 1'b0);
      KIND_ROW:
        predict_line_hold(c.first_row ? int'(FIRST_ROW_CLOCKS)
                                      : int'(OTHER_ROW_CLOCKS), 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string what, pin_pattern_t want,
                                          pin_pattern_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH %s at cycle %0d:", what, cycle_count);
      $display("  expected color=%02h le=%b row=%b last=%b",
               want.color_bits, want.latch_enable, want.row_line, want.last_beat);
      $display("  got      color=%02h le=%b row=%b last=%b",
               seen.color_bits, seen.latch_enable, seen.row_line, seen.last_beat);
    end
  endfunction

  // Watch both channels at each edge. Inputs and outputs all change by
  // nonblocking update, so the values read here are the ones the edge
  // samples. Commands are predicted before patterns are checked, so an
  // early pattern still finds its expectation.
  always @(posedge clk) begin : watch_channels
    led_command_t accepted;
    pin_pattern_t seen;
    pin_pattern_t want;
    string        bad_fields;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        accepted = '{in_kind, in_red_lo, in_green_lo, in_blue_lo, in_red_hi,
                     in_green_hi, in_blue_hi, in_latch, in_reg_addr,
                     in_reg_value, in_both_edges, in_first_row};
        predict_pin_train(accepted);
      end
      if (out_valid && !out_stall) begin
        seen = '{out_color_bits, out_latch_enable, out_row_line, out_last};
        if (expected_pins.size() == 0) begin
          report_mismatch("unexpected transfer", '0, seen);
        end else begin
          want = expected_pins.pop_front();
          bad_fields = "";
          if (seen.color_bits !== want.color_bits)     bad_fields = {bad_fields, " color_bits"};
          if (seen.latch_enable !== want.latch_enable) bad_fields = {bad_fields, " latch_enable"};
          if (seen.row_line !== want.row_line)         bad_fields = {bad_fields, " row_line"};
          if (seen.last_beat !== want.last_beat)       bad_fields = {bad_fields, " last"};
          if (bad_fields != "")
            report_mismatch({"in", bad_fields}, want, seen);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one command and hold it until the block takes it. Valid stays
  // high afterwards so a following command can go out back to back; it
  // only drops during a sender gap or a drain.
  task automatic send_command(led_command_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= c.kind;
    in_red_lo     <= c.red_lo;
    in_green_lo   <= c.green_lo;
    in_blue_lo    <= c.blue_lo;
    in_red_hi     <= c.red_hi;
    in_green_hi   <= c.green_hi;
    in_blue_hi    <= c.blue_hi;
    in_latch      <= c.latch;
    in_reg_addr   <= c.reg_addr;
    in_reg_value  <= c.reg_value;
    in_both_edges <= c.both_edges;
    in_first_row  <= c.first_row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed pattern has come out
  task automatic drain_patterns();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pins.size() != 0) @(posedge clk);
  endtask

  // All fields random; callers overwrite what they care about
  function automatic led_command_t random_fields();
    led_command_t c;
    c.kind       = 3'($urandom_range(7));
    c.red_lo     = 16'($urandom);
    c.green_lo   = 16'($urandom);
    c.blue_lo    = 16'($urandom);
    c.red_hi     = 16'($urandom);
    c.green_hi   = 16'($urandom);
    c.blue_hi    = 16'($urandom);
    c.latch      = 1'($urandom);
    c.reg_addr   = 8'($urandom);
    c.reg_value  = 8'($urandom);
    c.both_edges = 1'($urandom);
    c.first_row  = 1'($urandom);
    return c;
  endfunction

  function automatic led_command_t pixel_command(logic [15:0] r1, logic [15:0] g1,
                                                 logic [15:0] b1, logic [15:0] r2,
                                                 logic [15:0] g2, logic [15:0] b2,
                                                 logic le);
    led_command_t c;
    c = random_fields();
    c.kind     = KIND_PIXEL;
    c.red_lo   = r1;
    c.green_lo = g1;
    c.blue_lo  = b1;
    c.red_hi   = r2;
    c.green_hi = g2;
    c.blue_hi  = b2;
    c.latch    = le;
    return c;
  endfunction

  function automatic led_command_t register_command(logic [7:0] addr, logic [7:0] value,
                                                    logic le);
    led_command_t c;
    c = random_fields();
    c.kind      = KIND_REG;
    c.reg_addr  = addr;
    c.reg_value = value;
    c.latch     = le;
    return c;
  endfunction

  function automatic led_command_t pulse_command(logic [2:0] kind, logic dual,
                                                 logic first);
    led_command_t c;
    c = random_fields();
    c.kind       = kind;
    c.both_edges = dual;
    c.first_row  = first;
    return c;
  endfunction

  // Mostly real commands with random content; a few spare kinds as noise
  function automatic led_command_t random_command();
    led_command_t c;
    int           pick;
    c = random_fields();
    pick = $urandom_range(99);
    if (pick < 4)       c.kind = pick[0] ? KIND_SPARE_7 : KIND_SPARE_6;
    else if (pick < 40) c.kind = KIND_PIXEL;
    else if (pick < 60) c.kind = KIND_REG;
    else if (pick < 68) c.kind = KIND_VSYNC;
    else if (pick < 76) c.kind = KIND_PREACT;
    else if (pick < 88) c.kind = KIND_EDGE;
    else                c.kind = KIND_ROW;
    return c;
  endfunction

  // Lane extremes, alternating bits, and a distinct single bit per lane so a
  // lane swap or bit-order slip shows up
  task automatic test_pixel_words();
    send_command(pixel_command('0, '0, '0, '0, '0, '0, 1'b0));
    send_command(pixel_command('1, '1, '1, '1, '1, '1, 1'b1));
    send_command(pixel_command(16'hAAAA, 16'h5555, 16'hAAAA,
                               16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    send_command(pixel_command(16'h8000, 16'h0001, 16'h4000,
                               16'h0002, 16'h2000, 16'h0004, 1'b1));
  endtask

  // Address and value extremes, with and without the LE tail
  task automatic test_register_writes();
    send_command(register_command(8'h00, 8'h00, 1'b1));
    send_command(register_command(8'hFF, 8'hFF, 1'b0));
    send_command(register_command(8'hFF, 8'h00, 1'b1));
    send_command(register_command(8'h00, 8'hFF, 1'b1));
    send_command(register_command(8'hA5, 8'h5A, 1'b0));
  endtask

  // Each line-hold command, both lengths where there is a choice
  task automatic test_pulse_commands();
    send_command(pulse_command(KIND_VSYNC, 1'b0, 1'b0));
    send_command(pulse_command(KIND_PREACT, 1'b1, 1'b1));
    send_command(pulse_command(KIND_EDGE, 1'b1, 1'b0));
    send_command(pulse_command(KIND_EDGE, 1'b0, 1'b1));
    send_command(pulse_command(KIND_ROW, 1'b0, 1'b1));
    send_command(pulse_command(KIND_ROW, 1'b1, 1'b0));
  endtask

  // Spare kinds must vanish; the vsync after them must come out untouched
  task automatic test_unused_kinds();
    send_command(pulse_command(KIND_SPARE_6, 1'b1, 1'b1));
    send_command(pulse_command(KIND_SPARE_7, 1'b0, 1'b0));
    send_command(pulse_command(KIND_VSYNC, 1'b1, 1'b0));
  endtask

  // Let the block run dry mid-stream, then pick up again from idle
  task automatic test_drain_pause();
    repeat (3) send_command(random_command());
    drain_patterns();
    repeat (3) send_command(random_command());
  endtask

  // Random traffic; spare kinds do not count toward the total
  task automatic test_random_traffic(int count);
    led_command_t c;
    int           sent;
    sent = 0;
    while (sent < count) begin
      c = random_command();
      send_command(c);
      if (c.kind != KIND_SPARE_6 && c.kind != KIND_SPARE_7) sent++;
    end
  endtask

  initial begin
    // Synchronous reset, held low at the start of the run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles lightly, receiver stalls heavily
    send_idle_pct = 28;
    stall_pct     = 66;
    test_pixel_words();
    test_register_writes();
    test_pulse_commands();
    test_unused_kinds();
    test_drain_pause();
    test_random_traffic(170);

    // Phase two: roles swapped
    send_idle_pct = 66;
    stall_pct     = 28;
    test_random_traffic(170);

    // Phase three: full rate both ways
    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_traffic(165);

    drain_patterns();
    repeat (TAIL_CYCLES) @(posedge clk);
    // Anything still owed here counts against the block
    mismatch_count += expected_pins.size();

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ledser_pkg.sv
rtl/core/led_driver_command_serializer.sv
rtl/core/ledser_chk.sv
tb/led_driver_command_serializer_test.sv
